// ===== design/quaternion_smallest_three_codec_macros.svh =====
// assertion macros used by the codec module
`ifndef QUATERNION_SMALLEST_THREE_CODEC_MACROS_SVH
`define QUATERNION_SMALLEST_THREE_CODEC_MACROS_SVH

// same-cycle implication, off while reset is high
`define QS3C_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qs3c check failed");

// next-cycle implication, also checked across reset
`define QS3C_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qs3c check failed");

`endif

// ===== design/qs3c_pkg.sv =====
// shared constants, types and helper functions of the quaternion codec
package qs3c_pkg;

  localparam int DEF_FRACTION_BITS = 16;

  localparam int COMP_W = 18;
  localparam int WORD_W = 16;
  localparam int DATA_W = 120;

  typedef enum logic {
    OP_COMPRESS   = 1'b0,
    OP_DECOMPRESS = 1'b1
  } op_t;

  // index of the dropped component
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  localparam longint unsigned SCALE_NUM = 141421;
  localparam longint unsigned SCALE_DEN = 100000;
  localparam longint unsigned WORD_MAX  = 32767;
  localparam longint unsigned SCALE_K   = SCALE_NUM * WORD_MAX;
  localparam longint unsigned K_QUO     = SCALE_K / SCALE_DEN;
  localparam longint unsigned K_REM     = SCALE_K % SCALE_DEN;

  // reciprocal multipliers: compress shifts by fraction bits + CMP_SHIFT_BASE,
  // decompress shifts by DEC_SHIFT - fraction bits
  localparam int CMP_SHIFT_BASE = 35;
  localparam int DEC_SHIFT      = 66;
  localparam int MUL_W          = 51;
  localparam int MUL_LO_W       = 26;
  localparam int MUL_HI_W       = MUL_W - MUL_LO_W;

  // ceil(num * 2^shift / den) for num < den, by long division
  function automatic longint unsigned frac_ceil(input longint unsigned num,
                                                input longint unsigned den,
                                                input int shift);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = num;
    for (int i = 0; i < shift; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    if (r != 0) q = q + 1;
    return q;
  endfunction

  localparam logic [MUL_W-1:0] CMP_MUL =
    MUL_W'((K_QUO << CMP_SHIFT_BASE) + frac_ceil(K_REM, SCALE_DEN, CMP_SHIFT_BASE));
  localparam logic [MUL_W-1:0] DEC_MUL =
    MUL_W'(frac_ceil(SCALE_DEN, SCALE_K, DEC_SHIFT));

  function automatic logic [COMP_W-1:0] comp_mag(input logic signed [COMP_W-1:0] v);
    return v[COMP_W-1] ? COMP_W'(-v) : COMP_W'(v);
  endfunction

  function automatic logic [WORD_W-1:0] word_mag(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

endpackage

// ===== design/qs3c_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module qs3c_isqrt #(
  parameter int RAD_W = 34
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAD_W-1:0]     rad,
  output logic [RAD_W/2-1:0]   root
);

  localparam int N     = RAD_W / 2;
  localparam int REM_W = N + 2;

  logic [RAD_W-1:0] rad_q  [N];
  logic [REM_W-1:0] rem_q  [N];
  logic [N-1:0]     root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RAD_W-1:0] rad_i;
    logic [REM_W-1:0] rem_i;
    logic [N-1:0]     root_i;
    logic [REM_W+1:0] remx;
    logic [REM_W+1:0] sub;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
    end

    always_comb begin
      remx = {rem_i, rad_i[RAD_W-1 -: 2]};
      sub  = (REM_W+2)'({root_i, 2'b01});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k] <= rad_i << 2;
        if (remx >= sub) begin
          rem_q[k]  <= REM_W'(remx - sub);
          root_q[k] <= {root_i[N-2:0], 1'b1};
        end else begin
          rem_q[k]  <= REM_W'(remx);
          root_q[k] <= {root_i[N-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[N-1];

endmodule

// ===== design/quaternion_smallest_three_codec.sv =====
// Smallest-three quaternion codec, fully pipelined.
// s_axis carries one item per word: tuser is the opcode (0 compress, 1 decompress),
// tdata holds in_x, in_y, in_z, in_w (18 bits each) then word_a, word_b, word_c.
// m_axis returns one result word per item: packed_a, packed_b, packed_c then
// out_x, out_y, out_z, out_w. Unused fields of a result are zero.
// Compress drops the largest component and scales the other three into 16-bit
// words; bit 0 of the second and third words tags the dropped index.
// Decompress rescales the words and rebuilds the dropped component with a
// pipelined square root.
// Throughput is one item per cycle while the output is not stalled. From acceptance to
// m_axis_tvalid an item passes six arithmetic stages, FRACTION_BITS + 1 square
// root stages and the output register; compress items ride the same pipe.
// The whole pipe advances together; when the receiver holds m_axis_tready low
// with a result waiting, every stage holds and s_axis_tready drops.
// Reset clears all valid bits; no result is pending afterwards.
`include "quaternion_smallest_three_codec_macros.svh"

module quaternion_smallest_three_codec #(
  parameter int FRACTION_BITS = qs3c_pkg::DEF_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // in_x, in_y, in_z, in_w, word_a, word_b, word_c
  input  logic [qs3c_pkg::DATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // packed_a, packed_b, packed_c, out_x, out_y, out_z, out_w
  output logic [qs3c_pkg::DATA_W-1:0] m_axis_tdata
);

  import qs3c_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int SW     = F + 1;
  localparam int H      = (F + 1) / 2;
  localparam int HW     = F - H;
  localparam int SQ_W   = 2 * F;
  localparam int R_W    = 2 * F + 3;
  localparam int RAD_W  = 2 * F + 2;
  localparam int NST    = RAD_W / 2;
  localparam int DW     = F + 4;
  localparam int SH_C   = F + CMP_SHIFT_BASE;
  localparam int SH_D   = DEC_SHIFT - F;
  localparam int PLO_W  = COMP_W + MUL_LO_W;
  localparam int PHI_W  = COMP_W + MUL_HI_W;
  localparam int SUM_W  = COMP_W + MUL_W;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][COMP_W-1:0]       mag;
    logic [2:0]                   neg;
  } s1_t;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][PLO_W-1:0]        plo;
    logic [2:0][PHI_W-1:0]        phi;
    logic [2:0]                   neg;
  } s2_t;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][WORD_W-1:0]       pk;
    logic [2:0][F-1:0]            dmag;
    logic [2:0]                   dneg;
  } s3_t;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][WORD_W-1:0]       pk;
    logic [2:0][SW-1:0]           dval;
    logic [2:0][2*HW-1:0]         hh;
    logic [2:0][2*H-1:0]          ll;
    logic [2:0][HW+H-1:0]         hl;
  } s4_t;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][WORD_W-1:0]       pk;
    logic [2:0][SW-1:0]           dval;
    logic [2:0][SQ_W-1:0]         sq;
  } s5_t;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][WORD_W-1:0]       pk;
    logic [2:0][SW-1:0]           dval;
    logic [R_W-1:0]               rem;
  } s6_t;

  typedef struct packed {
    op_t                          op;
    logic [1:0]                   idx;
    logic [2:0][WORD_W-1:0]       pk;
    logic [2:0][SW-1:0]           dval;
    logic                         pos;
    logic [DW-1:0]                negv;
  } tail_t;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 1: pick the dropped component ----------------
  s1_t s1, s1_next;
  logic v1;

  logic signed [COMP_W-1:0] cx, cy, cz, cw;
  logic [COMP_W-1:0]        ax, ay, az, aw;
  logic signed [COMP_W-1:0] k0, k1, k2;
  logic                     flip;
  logic [1:0]               cidx;
  logic signed [WORD_W-1:0] wa, wb, wc;

  always_comb begin
    cx = s_axis_tdata[17:0];
    cy = s_axis_tdata[35:18];
    cz = s_axis_tdata[53:36];
    cw = s_axis_tdata[71:54];
    wa = s_axis_tdata[87:72];
    wb = {s_axis_tdata[103:89], 1'b0};
    wc = {s_axis_tdata[119:105], 1'b0};
    ax = comp_mag(cx);
    ay = comp_mag(cy);
    az = comp_mag(cz);
    aw = comp_mag(cw);

    priority if (aw > ax && aw > ay && aw > az) begin
      cidx = IDX_W; flip = cw[COMP_W-1]; k0 = cx; k1 = cy; k2 = cz;
    end else if (az > ax && az > ay) begin
      cidx = IDX_Z; flip = cz[COMP_W-1]; k0 = cx; k1 = cy; k2 = cw;
    end else if (ay > ax) begin
      cidx = IDX_Y; flip = cy[COMP_W-1]; k0 = cx; k1 = cz; k2 = cw;
    end else begin
      cidx = IDX_X; flip = cx[COMP_W-1]; k0 = cy; k1 = cz; k2 = cw;
    end

    s1_next.op = op_t'(s_axis_tuser);
    if (s1_next.op == OP_COMPRESS) begin
      s1_next.idx    = cidx;
      s1_next.mag[0] = comp_mag(k0);
      s1_next.mag[1] = comp_mag(k1);
      s1_next.mag[2] = comp_mag(k2);
      s1_next.neg    = {k2[COMP_W-1] ^ flip, k1[COMP_W-1] ^ flip, k0[COMP_W-1] ^ flip};
    end else begin
      s1_next.idx    = {s_axis_tdata[88], s_axis_tdata[104]};
      s1_next.mag[0] = COMP_W'(word_mag(wa));
      s1_next.mag[1] = COMP_W'(word_mag(wb));
      s1_next.mag[2] = COMP_W'(word_mag(wc));
      s1_next.neg    = {wc[WORD_W-1], wb[WORD_W-1], wa[WORD_W-1]};
    end
  end

  // ---------------- stage 2: reciprocal partial products ----------------
  s2_t s2, s2_next;
  logic v2;
  logic [MUL_LO_W-1:0] k_lo;
  logic [MUL_HI_W-1:0] k_hi;

  always_comb begin
    if (s1.op == OP_COMPRESS) begin
      k_lo = CMP_MUL[MUL_LO_W-1:0];
      k_hi = CMP_MUL[MUL_W-1:MUL_LO_W];
    end else begin
      k_lo = DEC_MUL[MUL_LO_W-1:0];
      k_hi = DEC_MUL[MUL_W-1:MUL_LO_W];
    end
    s2_next.op  = s1.op;
    s2_next.idx = s1.idx;
    s2_next.neg = s1.neg;
    for (int i = 0; i < 3; i++) begin
      s2_next.plo[i] = PLO_W'(s1.mag[i]) * PLO_W'(k_lo);
      s2_next.phi[i] = PHI_W'(s1.mag[i]) * PHI_W'(k_hi);
    end
  end

  // ---------------- stage 3: quotient, saturate, tag ----------------
  s3_t s3, s3_next;
  logic v3;
  logic [SUM_W-1:0]  psum [3];
  logic [SUM_W-1:0]  qc   [3];
  logic [SUM_W-1:0]  qd   [3];
  logic [14:0]       tq   [3];
  logic [WORD_W-1:0] wv   [3];

  always_comb begin
    s3_next.op  = s2.op;
    s3_next.idx = s2.idx;
    for (int i = 0; i < 3; i++) begin
      psum[i] = (SUM_W'(s2.phi[i]) << MUL_LO_W) + SUM_W'(s2.plo[i]);
      qc[i]   = psum[i] >> SH_C;
      qd[i]   = psum[i] >> SH_D;
      tq[i]   = (qc[i] > SUM_W'(WORD_MAX)) ? 15'(WORD_MAX) : qc[i][14:0];
      wv[i]   = s2.neg[i] ? (WORD_W'(0) - {1'b0, tq[i]}) : {1'b0, tq[i]};
    end
    if (s2.op == OP_COMPRESS) begin
      s3_next.pk[0] = wv[0];
      s3_next.pk[1] = {wv[1][WORD_W-1:1], s2.idx[1]};
      s3_next.pk[2] = {wv[2][WORD_W-1:1], s2.idx[0]};
    end else begin
      s3_next.pk = '0;
    end
    for (int i = 0; i < 3; i++) begin
      s3_next.dmag[i] = qd[i][F-1:0];
    end
    s3_next.dneg = s2.neg;
  end

  // ---------------- stage 4: signed components, square halves ----------------
  s4_t s4, s4_next;
  logic v4;
  logic [HW-1:0] ah [3];
  logic [H-1:0]  al [3];

  always_comb begin
    s4_next.op  = s3.op;
    s4_next.idx = s3.idx;
    s4_next.pk  = s3.pk;
    for (int i = 0; i < 3; i++) begin
      s4_next.dval[i] = s3.dneg[i] ? (SW'(0) - {1'b0, s3.dmag[i]}) : {1'b0, s3.dmag[i]};
      ah[i] = s3.dmag[i][F-1:H];
      al[i] = s3.dmag[i][H-1:0];
      s4_next.hh[i] = (2*HW)'(ah[i]) * (2*HW)'(ah[i]);
      s4_next.ll[i] = (2*H)'(al[i]) * (2*H)'(al[i]);
      s4_next.hl[i] = (HW+H)'(ah[i]) * (HW+H)'(al[i]);
    end
  end

  // ---------------- stage 5: assemble squares ----------------
  s5_t s5, s5_next;
  logic v5;

  always_comb begin
    s5_next.op   = s4.op;
    s5_next.idx  = s4.idx;
    s5_next.pk   = s4.pk;
    s5_next.dval = s4.dval;
    for (int i = 0; i < 3; i++) begin
      s5_next.sq[i] = (SQ_W'(s4.hh[i]) << (2*H)) + (SQ_W'(s4.hl[i]) << (H+1))
                      + SQ_W'(s4.ll[i]);
    end
  end

  // ---------------- stage 6: remainder ----------------
  s6_t s6, s6_next;
  logic v6;

  always_comb begin
    s6_next.op   = s5.op;
    s6_next.idx  = s5.idx;
    s6_next.pk   = s5.pk;
    s6_next.dval = s5.dval;
    s6_next.rem  = (R_W'(1) << SQ_W) - R_W'(s5.sq[0]) - R_W'(s5.sq[1]) - R_W'(s5.sq[2]);
  end

  // ---------------- square root and side pipe ----------------
  tail_t           tail_next;
  tail_t           tail [NST];
  logic [NST-1:0]  tv;
  logic [R_W-1:0]  nrem;
  logic [F+2:0]    nshift;
  logic [RAD_W-1:0] rad;
  logic [NST-1:0]  root;

  always_comb begin
    tail_next.op   = s6.op;
    tail_next.idx  = s6.idx;
    tail_next.pk   = s6.pk;
    tail_next.dval = s6.dval;
    tail_next.pos  = !s6.rem[R_W-1] && (s6.rem != '0);
    nrem           = R_W'(0) - s6.rem;
    nshift         = nrem[R_W-1:F];
    tail_next.negv = DW'(0) - {1'b0, nshift};
    rad            = tail_next.pos ? s6.rem[RAD_W-1:0] : '0;
  end

  qs3c_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  // ---------------- output stage ----------------
  tail_t                    tl;
  logic [DW-1:0]            dd;
  logic [COMP_W-1:0]        qa, qb, qc3, qdd;
  logic [3:0][COMP_W-1:0]   qo;
  logic [DATA_W-1:0]        out_next;

  always_comb begin
    tl  = tail[NST-1];
    dd  = tl.pos ? DW'(root) : tl.negv;
    qa  = COMP_W'($signed(tl.dval[0]));
    qb  = COMP_W'($signed(tl.dval[1]));
    qc3 = COMP_W'($signed(tl.dval[2]));
    qdd = COMP_W'($signed(dd));
    unique case (tl.idx)
      IDX_W:   qo = {qdd, qc3, qb,  qa};
      IDX_Z:   qo = {qc3, qdd, qb,  qa};
      IDX_Y:   qo = {qc3, qb,  qdd, qa};
      default: qo = {qc3, qb,  qa,  qdd};
    endcase
    if (tl.op == OP_COMPRESS) begin
      out_next = {72'd0, tl.pk[2], tl.pk[1], tl.pk[0]};
    end else begin
      out_next = {qo[3], qo[2], qo[1], qo[0], 48'd0};
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      tv <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      tv <= {tv[NST-2:0], v6};
      m_axis_tvalid <= tv[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
      tail[0] <= tail_next;
      for (int i = 1; i < NST; i++) begin
        tail[i] <= tail[i-1];
      end
      m_axis_tdata <= out_next;
    end
  end

  // ---------------- checks ----------------
  `QS3C_ASSERT_NXT(a_reset_empty, clk, rst, !m_axis_tvalid)
  `QS3C_ASSERT_IMP(a_word_saturated, clk, rst, m_axis_tvalid, m_axis_tdata[15:0] != 16'h8000)
  `QS3C_ASSERT_IMP(a_result_exclusive, clk, rst, m_axis_tvalid && (m_axis_tdata[47:0] != 48'd0), m_axis_tdata[119:48] == 72'd0)

endmodule

// ===== bench/tb_quaternion_smallest_three_codec.sv =====
// testbench for the smallest-three quaternion codec: directed and random items, checked against a predictor
`timescale 1ns / 1ps

module tb_quaternion_smallest_three_codec;
  import qs3c_pkg::*;

  localparam int FRAC = DEF_FRACTION_BITS;
  localparam int LATENCY = FRAC + 8;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;

  logic [DATA_W-1:0] expected_words[$];
  int errors = 0;
  int results_seen = 0;
  int n_compress = 0;
  int n_decompress = 0;
  longint cycles = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int rx_hold = 0;

  quaternion_smallest_three_codec u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [WORD_W-1:0] quantize(logic signed [COMP_W-1:0] c, bit flip);
    longint unsigned mag, t;
    bit neg;
    neg = (c < 0) != flip;
    mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
    t = (mag * SCALE_NUM * WORD_MAX) / (SCALE_DEN << FRAC);
    if (t > WORD_MAX) t = WORD_MAX;
    if (c == 0) neg = 1'b0;
    return neg ? WORD_W'(-t) : WORD_W'(t);
  endfunction

  function automatic longint expand(logic signed [WORD_W-1:0] s);
    longint unsigned mag, t;
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    t = ((mag << FRAC) * SCALE_DEN) / (WORD_MAX * SCALE_NUM);
    return (s < 0) ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] codec_predict(logic op, logic [DATA_W-1:0] d);
    logic signed [COMP_W-1:0] x, y, z, w;
    logic signed [WORD_W-1:0] wa, wb, wc;
    longint ax, ay, az, aw, a, b, c, r, rebuilt;
    logic [WORD_W-1:0] pa, pb, pc;
    logic [1:0] idx;
    longint q[4];
    logic [DATA_W-1:0] res;
    res = '0;
    if (op_t'(op) == OP_COMPRESS) begin
      x = d[17:0]; y = d[35:18]; z = d[53:36]; w = d[71:54];
      ax = (x < 0) ? -longint'(x) : x;
      ay = (y < 0) ? -longint'(y) : y;
      az = (z < 0) ? -longint'(z) : z;
      aw = (w < 0) ? -longint'(w) : w;
      if (aw > ax && aw > ay && aw > az) begin
        pa = quantize(x, w < 0);
        pb = (quantize(y, w < 0) & 16'hfffe) | 16'd1;
        pc = (quantize(z, w < 0) & 16'hfffe) | 16'd1;
      end else if (az > ax && az > ay) begin
        pa = quantize(x, z < 0);
        pb = (quantize(y, z < 0) & 16'hfffe) | 16'd1;
        pc = quantize(w, z < 0) & 16'hfffe;
      end else if (ay > ax) begin
        pa = quantize(x, y < 0);
        pb = quantize(z, y < 0) & 16'hfffe;
        pc = (quantize(w, y < 0) & 16'hfffe) | 16'd1;
      end else begin
        pa = quantize(y, x < 0);
        pb = quantize(z, x < 0) & 16'hfffe;
        pc = quantize(w, x < 0) & 16'hfffe;
      end
      res[47:0] = {pc, pb, pa};
    end else begin
      wa = d[87:72];
      wb = d[103:88] & 16'hfffe;
      wc = d[119:104] & 16'hfffe;
      idx = {d[88], d[104]};
      a = expand(wa);
      b = expand(wb);
      c = expand(wc);
      r = (longint'(1) << (2 * FRAC)) - a * a - b * b - c * c;
      if (r > 0) rebuilt = int_sqrt(r);
      else rebuilt = -((-r) >>> FRAC);
      case (idx)
        IDX_W: begin q[0] = a; q[1] = b; q[2] = c; q[3] = rebuilt; end
        IDX_Z: begin q[0] = a; q[1] = b; q[2] = rebuilt; q[3] = c; end
        IDX_Y: begin q[0] = a; q[1] = rebuilt; q[2] = b; q[3] = c; end
        default: begin q[0] = rebuilt; q[1] = a; q[2] = b; q[3] = c; end
      endcase
      res[119:48] = {COMP_W'(q[3]), COMP_W'(q[2]), COMP_W'(q[1]), COMP_W'(q[0])};
    end
    return res;
  endfunction

  // ---------------- monitor and checker ----------------
  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("error at %0t: %s got %0h expected %0h", $realtime, field, got, want);
  endtask

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(codec_predict(s_axis_tuser, s_axis_tdata));
        if (op_t'(s_axis_tuser) == OP_COMPRESS) n_compress++;
        else n_decompress++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[63:0], 0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[15:0] !== want[15:0])
            report_mismatch("packed_a", m_axis_tdata[15:0], want[15:0]);
          if (m_axis_tdata[31:16] !== want[31:16])
            report_mismatch("packed_b", m_axis_tdata[31:16], want[31:16]);
          if (m_axis_tdata[47:32] !== want[47:32])
            report_mismatch("packed_c", m_axis_tdata[47:32], want[47:32]);
          if (m_axis_tdata[65:48] !== want[65:48])
            report_mismatch("out_x", m_axis_tdata[65:48], want[65:48]);
          if (m_axis_tdata[83:66] !== want[83:66])
            report_mismatch("out_y", m_axis_tdata[83:66], want[83:66]);
          if (m_axis_tdata[101:84] !== want[101:84])
            report_mismatch("out_z", m_axis_tdata[101:84], want[101:84]);
          if (m_axis_tdata[119:102] !== want[119:102])
            report_mismatch("out_w", m_axis_tdata[119:102], want[119:102]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("quaternion_smallest_three_codec: mismatch");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold - 1) @(negedge clk);
        rx_hold = 0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_word(op_t op, logic [DATA_W-1:0] d);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_quat(logic [17:0] x, logic [17:0] y, logic [17:0] z, logic [17:0] w);
    logic [DATA_W-1:0] d;
    d = DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    d[71:0] = {w, z, y, x};
    send_word(OP_COMPRESS, d);
  endtask

  task automatic send_packed(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    logic [DATA_W-1:0] d;
    d = DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    d[119:72] = {c, b, a};
    send_word(OP_DECOMPRESS, d);
  endtask

  function automatic logic [17:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 18'($urandom());
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 46340)) - 23170);
    endcase
  endfunction

  task automatic send_random();
    if ($urandom_range(0, 1) == 0) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    else send_packed(rand_word(), rand_word(), rand_word());
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(18'd65536, 0, 0, 0);
    send_quat(0, 18'd65536, 0, 0);
    send_quat(0, 0, 18'd65536, 0);
    send_quat(0, 0, 0, 18'd65536);
    send_quat(-18'sd65536, 18'd100, -18'sd200, 18'd300);
    send_quat(18'd10, -18'sd65536, 18'd20, -18'sd30);
    send_quat(18'd10, 18'd20, -18'sd65536, 18'd30);
    send_quat(18'd10, -18'sd20, 18'd30, -18'sd65536);
    send_quat(18'h20000, 18'h1ffff, 18'h20000, 18'h1ffff);
    send_quat(18'd32768, 18'd32768, 18'd32768, 18'd32768);
    send_quat(18'd32768, -18'sd32768, 18'd32768, -18'sd32768);
    send_quat(18'h1ffff, 18'h20001, 18'h1fffe, 18'h3ffff);
    send_packed(0, 0, 0);
    send_packed(0, 16'd1, 0);
    send_packed(0, 0, 16'd1);
    send_packed(0, 16'd1, 16'd1);
    send_packed(16'h7fff, 16'h7fff, 16'h7fff);
    send_packed(16'h8000, 16'h8000, 16'h8000);
    send_packed(16'h8001, 16'hffff, 16'h7ffe);
    send_packed(16'd16384, 16'hc001, 16'd16385);
    send_packed(16'hffff, 16'hfffe, 16'hffff);
    drain();
  endtask

  task automatic test_random(int n);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (n) send_random();
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold = 300;
    repeat (80) send_random();
    drain();
  endtask

  task automatic test_full_rate(int n);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    test_backpressure();
    test_full_rate(170);
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d compress and %0d decompress items, %0d results checked",
             n_compress, n_decompress, results_seen);
    $display("with random stalls on both sides, a long output hold-off and a full-rate stretch");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("quaternion_smallest_three_codec: match");
    end else begin
      $display("quaternion_smallest_three_codec: mismatch");
    end
    $finish;
  end

endmodule
